>>> hw/rtl/dtbd_pkg.sv
// Package for the double top / double bottom detector.
// Holds the store sizes, price widths, register codes and the sequencer state type.
// It depends on nothing else.
`timescale 1ns / 1ps

package dtbd_pkg;

  // Store depth and price width
  localparam int DEPTH      = 256;
  localparam int PRICE_BITS = 32;

  // Derived widths
  localparam int ADDR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS  = ADDR_BITS + 1;
  localparam int IDX_BITS  = 8;
  localparam int PROD_BITS = PRICE_BITS + 8;
  localparam int PCT_SCALE = 100;

  // Configuration register widths
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 9;
  localparam int MIN_BITS       = 9;
  localparam int TOL_BITS       = 7;
  localparam int VALLEY_BITS    = 7;
  localparam int BOUNCE_BITS    = 8;

  // Configuration register indices
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_SAMPLES   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOLERANCE_PCT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_VALLEY_PCT    = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BOUNCE_PCT    = 2'd3;

  // Reset values of the configuration registers
  localparam logic [MIN_BITS-1:0]    MIN_SAMPLES_RST   = 9'd8;
  localparam logic [TOL_BITS-1:0]    TOLERANCE_PCT_RST = 7'd3;
  localparam logic [VALLEY_BITS-1:0] VALLEY_PCT_RST    = 7'd95;
  localparam logic [BOUNCE_BITS-1:0] BOUNCE_PCT_RST    = 8'd103;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN_EXT,
    ST_SETUP,
    ST_SCAN_SPAN,
    ST_MUL,
    ST_RESULT
  } state_t;

endpackage

>>> hw/rtl/double_top_bottom_detector_top.sv
// Top level of the double top / double bottom detector.
// Holds the two price stores, the scan sequencer and the result register.
// It depends on dtbd_pkg.
`timescale 1ns / 1ps

// Bars are written one per cycle into the high and low stores while bar_stall is low. On
// the bar that ends a frame of n bars the block runs two scans over the stores through
// their single read port: a first pass over the n bars finds the extreme of each half, and
// a second pass over the s bars from the leftmost to the rightmost extreme finds the
// valley and the bounce between them. A setup step between the passes forms the differences
// and bounds, and after the second pass a multiply step and a compare into the result
// register follow. A frame shorter than min_samples, or shorter than two bars, skips both
// scans and gives its word of zeros. bar_stall is high while a frame is being evaluated and
// while a finished word cannot be placed in the result register. Configuration may be
// written at any time the block is idle.
module double_top_bottom_detector_top (
  input  logic                                  clk,
  input  logic                                  rst,
  // Bar input channel
  input  logic                                  bar_valid,
  output logic                                  bar_stall,
  input  logic [dtbd_pkg::PRICE_BITS-1:0]       high_price,
  input  logic [dtbd_pkg::PRICE_BITS-1:0]       low_price,
  input  logic                                  frame_end,
  // Result channel
  output logic                                  res_valid,
  input  logic                                  res_stall,
  output logic                                  top_found,
  output logic [dtbd_pkg::IDX_BITS-1:0]         top_first,
  output logic [dtbd_pkg::IDX_BITS-1:0]         top_second,
  output logic                                  bottom_found,
  output logic [dtbd_pkg::IDX_BITS-1:0]         bottom_first,
  output logic [dtbd_pkg::IDX_BITS-1:0]         bottom_second,
  // Configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dtbd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [dtbd_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int AB = dtbd_pkg::ADDR_BITS;
  localparam int CB = dtbd_pkg::CNT_BITS;
  localparam int PB = dtbd_pkg::PRICE_BITS;
  localparam int XB = dtbd_pkg::PROD_BITS;

  dtbd_pkg::state_t state, state_next;

  // Configuration registers
  logic [dtbd_pkg::MIN_BITS-1:0]    min_samples;
  logic [dtbd_pkg::TOL_BITS-1:0]    tolerance_pct;
  logic [dtbd_pkg::VALLEY_BITS-1:0] valley_pct;
  logic [dtbd_pkg::BOUNCE_BITS-1:0] bounce_pct;

  // Frame bookkeeping
  logic [CB-1:0] bar_count;
  logic [CB-1:0] n_bars;
  logic          short_frame;
  logic [CB-1:0] n_new;
  logic          bar_fits;
  logic          bar_take;
  logic          frame_short;
  logic [AB-1:0] mid;

  // Stores and read pipeline
  logic [PB-1:0] high_mem [dtbd_pkg::DEPTH];
  logic [PB-1:0] low_mem  [dtbd_pkg::DEPTH];
  logic [PB-1:0] rd_high;
  logic [PB-1:0] rd_low;
  logic          mem_we;
  logic          rd_en;
  logic [CB-1:0] rd_ptr;
  logic          rd_vld;
  logic [AB-1:0] rd_idx;

  // Extremes of each half
  logic [AB-1:0] tl_idx, tr_idx, bl_idx, br_idx;
  logic [PB-1:0] tl_val, tr_val, bl_val, br_val;

  // Span scan
  logic [AB-1:0] span_lo, span_hi;
  logic [PB-1:0] top_ext, bot_ext;
  logic          scan_ext_last, scan_span_last;

  // Operands and products of the percentage tests
  logic [PB-1:0] t_diff, t_small, t_big, b_diff, b_big;
  logic [XB-1:0] p_tdiff, p_ttol, p_text, p_tval;
  logic [XB-1:0] p_bdiff, p_btol, p_bext, p_bbnc;
  logic          top_ok, bot_ok;

  // Control strobes
  logic out_free;
  logic res_load;

  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_samples   <= dtbd_pkg::MIN_SAMPLES_RST;
      tolerance_pct <= dtbd_pkg::TOLERANCE_PCT_RST;
      valley_pct    <= dtbd_pkg::VALLEY_PCT_RST;
      bounce_pct    <= dtbd_pkg::BOUNCE_PCT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dtbd_pkg::REG_MIN_SAMPLES:   min_samples   <= cfg_data[dtbd_pkg::MIN_BITS-1:0];
        dtbd_pkg::REG_TOLERANCE_PCT: tolerance_pct <= cfg_data[dtbd_pkg::TOL_BITS-1:0];
        dtbd_pkg::REG_VALLEY_PCT:    valley_pct    <= cfg_data[dtbd_pkg::VALLEY_BITS-1:0];
        dtbd_pkg::REG_BOUNCE_PCT:    bounce_pct    <= cfg_data[dtbd_pkg::BOUNCE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Frame length and short-frame test for the bar on hand
  assign bar_fits    = (bar_count < CB'(dtbd_pkg::DEPTH));
  assign n_new       = bar_fits ? bar_count + 1'b1 : bar_count;
  assign frame_short = (n_new < CB'(2)) || (n_new < CB'(min_samples));
  assign mid         = n_bars[CB-1:1];

  // Ends of the two scans
  assign scan_ext_last  = rd_vld && ({1'b0, rd_idx} == n_bars - 1'b1);
  assign span_lo        = (tl_idx < bl_idx) ? tl_idx : bl_idx;
  assign span_hi        = (tr_idx > br_idx) ? tr_idx : br_idx;
  assign scan_span_last = rd_vld && (rd_idx == span_hi);

  assign out_free = !res_valid || !res_stall;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      dtbd_pkg::ST_LOAD: begin
        if (bar_valid && !bar_stall && frame_end) begin
          state_next = frame_short ? dtbd_pkg::ST_RESULT : dtbd_pkg::ST_SCAN_EXT;
        end
      end
      dtbd_pkg::ST_SCAN_EXT: begin
        if (scan_ext_last) state_next = dtbd_pkg::ST_SETUP;
      end
      dtbd_pkg::ST_SETUP:     state_next = dtbd_pkg::ST_SCAN_SPAN;
      dtbd_pkg::ST_SCAN_SPAN: begin
        if (scan_span_last) state_next = dtbd_pkg::ST_MUL;
      end
      dtbd_pkg::ST_MUL:       state_next = dtbd_pkg::ST_RESULT;
      dtbd_pkg::ST_RESULT: begin
        if (out_free) state_next = dtbd_pkg::ST_LOAD;
      end
      default:                state_next = dtbd_pkg::ST_LOAD;
    endcase
  end

  // Control outputs of the sequencer
  always_comb begin
    bar_stall = 1'b1;
    mem_we    = 1'b0;
    rd_en     = 1'b0;
    res_load  = 1'b0;
    case (state)
      dtbd_pkg::ST_LOAD: begin
        bar_stall = 1'b0;
        mem_we    = bar_valid && bar_fits;
      end
      dtbd_pkg::ST_SCAN_EXT:  rd_en = (rd_ptr < n_bars);
      dtbd_pkg::ST_SCAN_SPAN: rd_en = (rd_ptr <= {1'b0, span_hi});
      dtbd_pkg::ST_RESULT:    res_load = out_free;
      default: ;
    endcase
  end

  assign bar_take = bar_valid && !bar_stall;

  // State register and frame counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dtbd_pkg::ST_LOAD;
      bar_count <= '0;
      rd_vld    <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_en;
      if (bar_take) begin
        bar_count <= frame_end ? '0 : n_new;
      end
    end
  end

  // Frame length captured on the closing bar
  always_ff @(posedge clk) begin
    if (bar_take && frame_end) begin
      n_bars      <= n_new;
      short_frame <= frame_short;
    end
  end

  // Price stores: one write port for loading, one registered read port for scanning.
  // Writes happen only while loading and read data is used only while scanning, so they never meet.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      high_mem[bar_count[AB-1:0]] <= high_price;
      low_mem[bar_count[AB-1:0]]  <= low_price;
    end
    rd_high <= high_mem[rd_ptr[AB-1:0]];
    rd_low  <= low_mem[rd_ptr[AB-1:0]];
  end

  // Read pointer: walks the whole frame, then the span between the extremes
  always_ff @(posedge clk) begin
    if (bar_take && frame_end) begin
      rd_ptr <= '0;
    end else if (state == dtbd_pkg::ST_SETUP) begin
      rd_ptr <= {1'b0, span_lo};
    end else if (rd_en) begin
      rd_ptr <= rd_ptr + 1'b1;
    end
    if (rd_en) rd_idx <= rd_ptr[AB-1:0];
  end

  // First pass: first maximum high and first minimum low in each half
  always_ff @(posedge clk) begin
    if (state == dtbd_pkg::ST_SCAN_EXT && rd_vld) begin
      if (rd_idx < mid) begin
        if (rd_idx == '0 || rd_high > tl_val) begin
          tl_idx <= rd_idx;
          tl_val <= rd_high;
        end
        if (rd_idx == '0 || rd_low < bl_val) begin
          bl_idx <= rd_idx;
          bl_val <= rd_low;
        end
      end else begin
        if (rd_idx == mid || rd_high > tr_val) begin
          tr_idx <= rd_idx;
          tr_val <= rd_high;
        end
        if (rd_idx == mid || rd_low < br_val) begin
          br_idx <= rd_idx;
          br_val <= rd_low;
        end
      end
    end
  end

  // Differences and bounds of the peak pair and the trough pair
  always_ff @(posedge clk) begin
    if (state == dtbd_pkg::ST_SETUP) begin
      t_diff  <= (tl_val > tr_val) ? tl_val - tr_val : tr_val - tl_val;
      t_big   <= (tl_val > tr_val) ? tl_val : tr_val;
      t_small <= (tl_val < tr_val) ? tl_val : tr_val;
      b_diff  <= (bl_val > br_val) ? bl_val - br_val : br_val - bl_val;
      b_big   <= (bl_val > br_val) ? bl_val : br_val;
    end
  end

  // Second pass: lowest low between the peaks and highest high between the troughs.
  // The scan starts at the leftmost extreme, so each range meets its own start first.
  always_ff @(posedge clk) begin
    if (state == dtbd_pkg::ST_SCAN_SPAN && rd_vld) begin
      if (rd_idx == tl_idx) begin
        top_ext <= rd_low;
      end else if (rd_idx > tl_idx && rd_idx <= tr_idx && rd_low < top_ext) begin
        top_ext <= rd_low;
      end
      if (rd_idx == bl_idx) begin
        bot_ext <= rd_high;
      end else if (rd_idx > bl_idx && rd_idx <= br_idx && rd_high > bot_ext) begin
        bot_ext <= rd_high;
      end
    end
  end

  // Cross-multiplied percentage terms, one product per path
  always_ff @(posedge clk) begin
    if (state == dtbd_pkg::ST_MUL) begin
      p_tdiff <= XB'(t_diff)  * XB'(dtbd_pkg::PCT_SCALE);
      p_ttol  <= XB'(t_big)   * XB'(tolerance_pct);
      p_text  <= XB'(top_ext) * XB'(dtbd_pkg::PCT_SCALE);
      p_tval  <= XB'(t_small) * XB'(valley_pct);
      p_bdiff <= XB'(b_diff)  * XB'(dtbd_pkg::PCT_SCALE);
      p_btol  <= XB'(b_big)   * XB'(tolerance_pct);
      p_bext  <= XB'(bot_ext) * XB'(dtbd_pkg::PCT_SCALE);
      p_bbnc  <= XB'(b_big)   * XB'(bounce_pct);
    end
  end

  // Pattern decisions
  assign top_ok = !short_frame && (p_tdiff <= p_ttol) && (p_text < p_tval);
  assign bot_ok = !short_frame && (p_bdiff <= p_btol) && (p_bext > p_bbnc);

  // Result register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // Result register: payload; indices read as zero when a pattern is not found
  always_ff @(posedge clk) begin
    if (res_load) begin
      top_found     <= top_ok;
      top_first     <= top_ok ? dtbd_pkg::IDX_BITS'(tl_idx) : '0;
      top_second    <= top_ok ? dtbd_pkg::IDX_BITS'(tr_idx) : '0;
      bottom_found  <= bot_ok;
      bottom_first  <= bot_ok ? dtbd_pkg::IDX_BITS'(bl_idx) : '0;
      bottom_second <= bot_ok ? dtbd_pkg::IDX_BITS'(br_idx) : '0;
    end
  end

  // The left extreme always lies in the first half and the right one in the second
  a_top_order: assert property (@(posedge clk) disable iff (rst)
    res_valid && top_found |-> top_first < top_second)
    else $error("double top indices out of order");

  a_bottom_order: assert property (@(posedge clk) disable iff (rst)
    res_valid && bottom_found |-> bottom_first < bottom_second)
    else $error("double bottom indices out of order");

  // The frame counter never passes the store depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    bar_count <= CB'(dtbd_pkg::DEPTH))
    else $error("bar count beyond store depth");

  // Every read returned during the first pass lies inside the frame
  a_read_in_frame: assert property (@(posedge clk) disable iff (rst)
    (state == dtbd_pkg::ST_SCAN_EXT) && rd_vld |-> {1'b0, rd_idx} < n_bars)
    else $error("store read outside the frame");

endmodule
